>>> rtl/core/pcst_pkg.sv
// Shared types and constants for the periodic callback slot table.
`timescale 1ns / 1ps

package pcst_pkg;

   localparam int unsigned SLOTS_DEFAULT = 8;
   localparam int unsigned MAX_FIRES     = 8;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  handle;
      logic [15:0] period;
   } pcst_req_type;

   typedef struct packed {
      logic [7:0] fired_handle;
      logic [5:0] fired_slot;
      logic       last_fire;
   } pcst_rsp_type;

endpackage

>>> rtl/core/periodic_callback_slot_table_top.sv
// Periodic callback slot table: slot memory, walk sequencer and fire output.
`timescale 1ns / 1ps

// Every item walks the slot memory one slot per cycle unless paused, and no
// new item is taken until it is done. A firing tick ends in a flush state
// that releases its final fire transfer. The walk pauses only while a reported
// fire must push the held fire into a full, stalled output register. Only the
// first MAX_FIRES fires of a tick are reported, in slot order, and the final
// one carries last_fire; every firing counter still reloads. Occupancy flags
// reset at once, so no clearing pass is needed after reset.
module periodic_callback_slot_table_top #(
   parameter int unsigned SLOTS = pcst_pkg::SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcst_pkg::pcst_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcst_pkg::pcst_rsp_type rsp_data
);
   import pcst_pkg::*;

   localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned IW = $clog2(SLOTS + 1);
   localparam int unsigned NW = $clog2(MAX_FIRES + 1);

   typedef struct packed {
      logic [7:0]  handle;
      logic [15:0] counter;
      logic [15:0] period;
   } entry_type;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_type;

   entry_type    mem [SLOTS];
   entry_type    rd_data_ff;
   entry_type    wr_entry;
   logic         rd_en;
   logic         wr_en;

   state_type    state_ff, state_in;
   logic [IW-1:0] ri_ff, ri_in;
   logic         pv_ff, pv_in;
   logic [SW-1:0] pidx_ff, pidx_in;
   logic         hit_ff, hit_in;
   logic [NW-1:0] n_ff, n_in;
   logic         pend_v_ff, pend_v_in;
   pcst_rsp_type pend_ff, pend_in;
   logic [SLOTS-1:0] occ_ff, occ_in;
   pcst_req_type item_ff, item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   pcst_rsp_type rsp_ff, rsp_in;

   logic         occ_p;
   logic [15:0]  cnt_dec;
   logic         fire;
   logic         rep;
   logic         out_free;
   logic         adv;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      occ_p    = occ_ff[pidx_ff];
      cnt_dec  = rd_data_ff.counter - 16'd1;
      fire     = pv_ff && (item_ff.opcode == OP_TICK) && occ_p && (cnt_dec == 16'd0);
      rep      = fire && (n_ff < NW'(MAX_FIRES));
      out_free = !rsp_valid_ff || !rsp_stall;
      adv      = !(rep && pend_v_ff && !out_free);

      state_in     = state_ff;
      ri_in        = ri_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      n_in         = n_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      occ_in       = occ_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_entry     = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               ri_in    = '0;
               pv_in    = 1'b0;
               hit_in   = 1'b0;
               n_in     = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (adv) begin
               if (pv_ff) begin
                  priority if (item_ff.opcode == OP_TICK) begin
                     if (occ_p) begin
                        wr_en            = 1'b1;
                        wr_entry.counter = (cnt_dec == 16'd0) ? rd_data_ff.period : cnt_dec;
                     end
                     if (rep) begin
                        n_in                 = n_ff + NW'(1);
                        pend_in.fired_handle = rd_data_ff.handle;
                        pend_in.fired_slot   = 6'(pidx_ff);
                        pend_in.last_fire    = 1'b0;
                        pend_v_in            = 1'b1;
                        if (pend_v_ff) begin
                           rsp_in       = pend_ff;
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end else if (item_ff.opcode == OP_ADD) begin
                     if (!hit_ff && (item_ff.handle != 8'd0) && !occ_p) begin
                        wr_en            = 1'b1;
                        wr_entry.handle  = item_ff.handle;
                        wr_entry.counter = item_ff.period;
                        wr_entry.period  = item_ff.period;
                        occ_in[pidx_ff]  = 1'b1;
                        hit_in           = 1'b1;
                     end
                  end else if (item_ff.opcode == OP_REMOVE) begin
                     if (!hit_ff && (item_ff.handle != 8'd0) && occ_p &&
                         (rd_data_ff.handle == item_ff.handle)) begin
                        occ_in[pidx_ff] = 1'b0;
                        hit_in          = 1'b1;
                     end
                  end else begin
                     hit_in = hit_ff;
                  end
               end
               if (ri_ff < IW'(SLOTS)) begin
                  rd_en   = 1'b1;
                  pv_in   = 1'b1;
                  pidx_in = ri_ff[SW-1:0];
                  ri_in   = ri_ff + IW'(1);
               end else begin
                  pv_in    = 1'b0;
                  state_in = (pend_v_ff || rep) ? S_FLUSH : S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_in           = pend_ff;
               rsp_in.last_fire = 1'b1;
               rsp_valid_in     = 1'b1;
               pend_v_in        = 1'b0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ri_ff        <= '0;
         pv_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         n_ff         <= '0;
         pend_v_ff    <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ri_ff        <= ri_in;
         pv_ff        <= pv_in;
         hit_ff       <= hit_in;
         n_ff         <= n_in;
         pend_v_ff    <= pend_v_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      pend_ff <= pend_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pidx_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ri_ff[SW-1:0]];
      end
   end

endmodule

>>> tb/periodic_callback_slot_table_top_tb.sv
// Self-checking testbench for the periodic callback slot table with a slot-table predictor.
`timescale 1ns / 1ps

module periodic_callback_slot_table_top_tb;
   import pcst_pkg::*;

   localparam int unsigned SLOTS       = SLOTS_DEFAULT;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_LIMIT  = 5000;
   localparam int unsigned DRAIN_WAIT  = 4 * SLOTS + 16;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pcst_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pcst_rsp_type rsp_data;

   logic [7:0]  tbl_handle [SLOTS] = '{default: 8'd0};
   logic [15:0] tbl_count  [SLOTS] = '{default: 16'd0};
   logic [15:0] tbl_period [SLOTS] = '{default: 16'd0};

   pcst_rsp_type pending_fires[$];
   int unsigned  error_count = 0;
   int unsigned  quiet_cycles = 0;
   bit           quiet = 1'b0;
   bit           hold_pending = 1'b0;

   periodic_callback_slot_table_top #(.SLOTS(SLOTS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic pcst_req_type make_item(input logic [1:0] op, input logic [7:0] h,
                                               input logic [15:0] p);
      pcst_req_type item;
      item.opcode = op;
      item.handle = h;
      item.period = p;
      return item;
   endfunction

   function automatic void predict_item(input pcst_req_type item);
      pcst_rsp_type fires[$];
      pcst_rsp_type fire;
      case (item.opcode)
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_handle[i] != 8'd0) begin
                  tbl_count[i] = tbl_count[i] - 16'd1;
                  if (tbl_count[i] == 16'd0) begin
                     tbl_count[i] = tbl_period[i];
                     if (fires.size() < MAX_FIRES) begin
                        fire.fired_handle = tbl_handle[i];
                        fire.fired_slot   = 6'(i);
                        fire.last_fire    = 1'b0;
                        fires.push_back(fire);
                     end
                  end
               end
            end
            if (fires.size() > 0)
               fires[fires.size() - 1].last_fire = 1'b1;
            foreach (fires[k])
               pending_fires.push_back(fires[k]);
         end
         OP_ADD: begin
            if (item.handle != 8'd0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_handle[i] == 8'd0) begin
                     tbl_handle[i] = item.handle;
                     tbl_count[i]  = item.period;
                     tbl_period[i] = item.period;
                     break;
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (item.handle != 8'd0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_handle[i] == item.handle) begin
                     tbl_handle[i] = 8'd0;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input pcst_req_type item);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_item(item);
   endtask

   // receiver: random stall, or a long hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 26);
         end
      end
   end

   // check each fire transfer and watch for a hung block
   always @(posedge clock) begin
      pcst_rsp_type exp_fire;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("periodic_callback_slot_table_top_tb: done, errors");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_fires.size() == 0) begin
               report_mismatch($sformatf("unexpected fire handle %0d slot %0d",
                                         rsp_data.fired_handle, rsp_data.fired_slot));
            end else begin
               exp_fire = pending_fires.pop_front();
               if (rsp_data.fired_handle !== exp_fire.fired_handle)
                  report_mismatch($sformatf("fired_handle got %0d want %0d",
                                            rsp_data.fired_handle, exp_fire.fired_handle));
               if (rsp_data.fired_slot !== exp_fire.fired_slot)
                  report_mismatch($sformatf("fired_slot got %0d want %0d",
                                            rsp_data.fired_slot, exp_fire.fired_slot));
               if (rsp_data.last_fire !== exp_fire.last_fire)
                  report_mismatch($sformatf("last_fire got %0d want %0d",
                                            rsp_data.last_fire, exp_fire.last_fire));
            end
         end
      end
   end

   task automatic test_empty_table;
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
      send_item(make_item(OP_UNUSED, 8'd255, 16'hFFFF));
      send_item(make_item(OP_REMOVE, 8'd5, 16'd0));
      send_item(make_item(OP_REMOVE, 8'd0, 16'd0));
      send_item(make_item(OP_ADD, 8'd0, 16'd1));
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
   endtask

   task automatic test_full_table;
      logic [7:0] handles [8] = '{8'd1, 8'd255, 8'h55, 8'hAA, 8'd7, 8'd7, 8'h80, 8'h40};
      foreach (handles[i])
         send_item(make_item(OP_ADD, handles[i], 16'd1));
      send_item(make_item(OP_ADD, 8'd9, 16'd1));
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
      send_item(make_item(OP_REMOVE, 8'd7, 16'd0));
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
   endtask

   task automatic test_period_extremes;
      send_item(make_item(OP_REMOVE, 8'd255, 16'd0));
      send_item(make_item(OP_ADD, 8'd255, 16'd0));
      send_item(make_item(OP_REMOVE, 8'h55, 16'd0));
      send_item(make_item(OP_ADD, 8'h33, 16'hFFFF));
      send_item(make_item(OP_ADD, 8'h12, 16'd2));
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
      send_item(make_item(OP_TICK, 8'd0, 16'd0));
   endtask

   task automatic test_backpressure;
      hold_pending = 1'b1;
      repeat (12)
         send_item(make_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom)));
   endtask

   task automatic test_random_traffic;
      int unsigned roll;
      logic [7:0]  h;
      logic [15:0] p;
      for (int n = 0; n < 93; n++) begin
         quiet = (n >= 40 && n < 70);
         roll = $urandom_range(0, 99);
         h = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
         if (roll < 55) begin
            send_item(make_item(OP_TICK, h, p));
         end else if (roll < 77) begin
            send_item(make_item(OP_ADD, h, p));
         end else if (roll < 95) begin
            if ($urandom_range(0, 3) != 0)
               h = tbl_handle[$urandom_range(0, SLOTS - 1)];
            send_item(make_item(OP_REMOVE, h, p));
         end else begin
            send_item(make_item(OP_UNUSED, h, p));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_full_table();
      test_period_extremes();
      test_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_fires.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("periodic_callback_slot_table_top_tb: done, clean");
      else
         $display("periodic_callback_slot_table_top_tb: done, errors");
      $finish;
   end

endmodule
